// File: sv/rsie_pkg.sv
// Package with opcode and function codes for the instruction executor.
`timescale 1ns / 1ps
`default_nettype none

package rsie_pkg;

   // Primary opcodes (bits 31..26)
   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_J     = 6'b000010;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_ADDI  = 6'b001000;
   localparam logic [5:0] OP_LW    = 6'b100011;
   localparam logic [5:0] OP_SW    = 6'b101011;

   // R-type function codes (bits 5..0)
   localparam logic [5:0] FN_ADD = 6'b100000;
   localparam logic [5:0] FN_SUB = 6'b100010;
   localparam logic [5:0] FN_AND = 6'b100100;
   localparam logic [5:0] FN_OR  = 6'b100101;
   localparam logic [5:0] FN_SLT = 6'b101010;

   typedef logic [31:0] word_type;
   typedef logic [4:0]  reg_idx_type;

endpackage

`default_nettype wire

// File: sv/risc_subset_instruction_executor.sv
// Instruction executor: register file and data memory in synchronous RAMs, PC in a register.
// The instruction is registered into the execute stage at accept, then into the output register, where rsp_valid rises.
// Throughput: one instruction per cycle while rsp_ready stays high; the execute stage and the output register
//   overlap, with the register file read at accept and the data memory read in execute.
// Reset: PC and register file (through per-entry valid bits) clear at once; the data
//   memory is then swept to zero, one word a cycle, with req_ready low until all
//   DATA_WORDS words are cleared.
`timescale 1ns / 1ps
`default_nettype none

module risc_subset_instruction_executor #(
   parameter int DATA_WORDS = 256
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  rsie_pkg::word_type    req_instruction,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output rsie_pkg::word_type     rsp_next_pc,
   output logic                   rsp_reg_write,
   output rsie_pkg::reg_idx_type  rsp_reg_dest,
   output rsie_pkg::word_type     rsp_reg_value,
   output logic                   rsp_mem_write,
   output rsie_pkg::word_type     rsp_mem_address,
   output rsie_pkg::word_type     rsp_mem_value,
   output logic                   rsp_status
);

   import rsie_pkg::*;

   localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

   // ---------------- storage ----------------
   word_type          rf_mem [32];
   logic [31:0]       rf_vld_ff;
   word_type          dmem [DATA_WORDS];
   word_type          dmem_q_ff;

   // ---------------- control ----------------
   logic              clearing_ff;
   logic [AW-1:0]     clr_cnt_ff;
   word_type          pc_ff;

   // execute stage
   logic              ex_valid_ff;
   word_type          ex_instr_ff;
   word_type          ex_rfa_ff, ex_rfb_ff;
   logic              ex_vlda_ff, ex_vldb_ff;
   logic              ex_bypa_ff, ex_bypb_ff;
   word_type          ex_byp_data_ff;

   // output stage
   logic              out_valid_ff;
   word_type          out_next_pc_ff;
   logic              out_rw_ff;
   reg_idx_type       out_dest_ff;
   word_type          out_val_ff;
   logic              out_mw_ff;
   word_type          out_maddr_ff;
   word_type          out_mval_ff;
   logic              out_status_ff;
   logic              out_is_lw_ff;
   logic              out_inrange_ff;

   logic              accept, ex_fire, out_free, rsp_take;
   logic              rf_we;
   word_type          out_wdata, ld_data;

   // execute results
   word_type          op_a, op_b, base_a, base_b;
   word_type          next_pc_in, val_in, maddr_in, mval_in;
   logic              rw_in, mw_in, status_in, is_lw_in, inrange_in;
   reg_idx_type       dest_in;
   logic              dm_re, dm_swe;
   logic [AW-1:0]     dm_idx;

   logic [5:0]        ex_op, ex_fn;
   reg_idx_type       ex_rs, ex_rt, ex_rd;
   word_type          ex_imm, pc4, sum;
   logic [29:0]       word_idx;

   // ---------------- handshake ----------------
   assign out_free  = !out_valid_ff || rsp_ready;
   assign ex_fire   = ex_valid_ff && out_free;
   assign req_ready = !clearing_ff && (!ex_valid_ff || ex_fire);
   assign accept    = req_valid && req_ready;
   assign rsp_take  = out_valid_ff && rsp_ready;

   // ---------------- writeback value ----------------
   assign ld_data   = out_inrange_ff ? dmem_q_ff : '0;
   assign out_wdata = out_is_lw_ff ? ld_data : out_val_ff;
   assign rf_we     = rsp_take && out_rw_ff;

   // ---------------- register file ----------------
   // Read both sources at accept; a write on the same edge is passed through.
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[out_dest_ff] <= out_wdata;
      end
      if (accept) begin
         ex_rfa_ff      <= rf_mem[req_instruction[25:21]];
         ex_rfb_ff      <= rf_mem[req_instruction[20:16]];
         ex_vlda_ff     <= rf_vld_ff[req_instruction[25:21]];
         ex_vldb_ff     <= rf_vld_ff[req_instruction[20:16]];
         ex_bypa_ff     <= rf_we && (out_dest_ff == req_instruction[25:21]);
         ex_bypb_ff     <= rf_we && (out_dest_ff == req_instruction[20:16]);
         ex_byp_data_ff <= out_wdata;
         ex_instr_ff    <= req_instruction;
      end
   end

   // Track written entries; an unwritten entry reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[out_dest_ff] <= 1'b1;
      end
   end

   // ---------------- data memory ----------------
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         dmem[clr_cnt_ff] <= '0;
      end else if (dm_swe) begin
         dmem[dm_idx] <= op_b;
      end
      if (dm_re) begin
         dmem_q_ff <= dmem[dm_idx];
      end
   end

   // Sweep the data memory after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(DATA_WORDS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ---------------- execute ----------------
   // Forward the pending write from the output stage ahead of the file.
   always_comb begin
      ex_op  = ex_instr_ff[31:26];
      ex_rs  = ex_instr_ff[25:21];
      ex_rt  = ex_instr_ff[20:16];
      ex_rd  = ex_instr_ff[15:11];
      ex_fn  = ex_instr_ff[5:0];
      ex_imm = {{16{ex_instr_ff[15]}}, ex_instr_ff[15:0]};

      base_a = ex_bypa_ff ? ex_byp_data_ff : (ex_vlda_ff ? ex_rfa_ff : '0);
      base_b = ex_bypb_ff ? ex_byp_data_ff : (ex_vldb_ff ? ex_rfb_ff : '0);
      op_a   = (out_valid_ff && out_rw_ff && (out_dest_ff == ex_rs)) ? out_wdata : base_a;
      op_b   = (out_valid_ff && out_rw_ff && (out_dest_ff == ex_rt)) ? out_wdata : base_b;

      pc4      = pc_ff + 32'd4;
      sum      = op_a + ex_imm;
      word_idx = sum[31:2];
      dm_idx   = sum[AW+1:2];
   end

   // Decode and compute the result fields.
   always_comb begin
      next_pc_in = pc4;
      rw_in      = 1'b0;
      dest_in    = '0;
      val_in     = '0;
      mw_in      = 1'b0;
      maddr_in   = '0;
      mval_in    = '0;
      status_in  = 1'b0;
      is_lw_in   = 1'b0;
      inrange_in = word_idx < 30'(DATA_WORDS);
      case (ex_op)
         OP_RTYPE: begin
            rw_in   = 1'b1;
            dest_in = ex_rd;
            case (ex_fn)
               FN_ADD:  val_in = op_a + op_b;
               FN_SUB:  val_in = op_a - op_b;
               FN_AND:  val_in = op_a & op_b;
               FN_OR:   val_in = op_a | op_b;
               FN_SLT:  val_in = {31'd0, $signed(op_a) < $signed(op_b)};
               default: begin
                  rw_in     = 1'b0;
                  dest_in   = '0;
                  status_in = 1'b1;
               end
            endcase
         end
         OP_ADDI: begin
            rw_in   = 1'b1;
            dest_in = ex_rt;
            val_in  = sum;
         end
         OP_LW: begin
            rw_in    = 1'b1;
            dest_in  = ex_rt;
            maddr_in = sum;
            is_lw_in = 1'b1;
         end
         OP_SW: begin
            mw_in    = 1'b1;
            maddr_in = sum;
            mval_in  = op_b;
         end
         OP_BEQ: begin
            if (op_a == op_b) begin
               next_pc_in = pc4 + {ex_imm[29:0], 2'b00};
            end
         end
         OP_J: begin
            next_pc_in = {pc4[31:28], ex_instr_ff[25:0], 2'b00};
         end
         default: begin
            status_in = 1'b1;
         end
      endcase
      // drop writes to register zero
      if (dest_in == '0) begin
         rw_in   = 1'b0;
         dest_in = '0;
         val_in  = '0;
      end
   end

   assign dm_re  = ex_fire && (ex_op == OP_LW);
   assign dm_swe = ex_fire && (ex_op == OP_SW) && inrange_in;

   // ---------------- pipeline control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
      end else begin
         if (accept) begin
            ex_valid_ff <= 1'b1;
         end else if (ex_fire) begin
            ex_valid_ff <= 1'b0;
         end
         if (ex_fire) begin
            out_valid_ff <= 1'b1;
            pc_ff        <= next_pc_in;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Load the output register.
   always_ff @(posedge clock) begin
      if (ex_fire) begin
         out_next_pc_ff <= next_pc_in;
         out_rw_ff      <= rw_in;
         out_dest_ff    <= dest_in;
         out_val_ff     <= val_in;
         out_mw_ff      <= mw_in;
         out_maddr_ff   <= maddr_in;
         out_mval_ff    <= mval_in;
         out_status_ff  <= status_in;
         out_is_lw_ff   <= is_lw_in;
         out_inrange_ff <= inrange_in;
      end
   end

   // ---------------- outputs ----------------
   assign rsp_valid       = out_valid_ff;
   assign rsp_next_pc     = out_next_pc_ff;
   assign rsp_reg_write   = out_rw_ff;
   assign rsp_reg_dest    = out_dest_ff;
   assign rsp_reg_value   = out_rw_ff ? out_wdata : '0;
   assign rsp_mem_write   = out_mw_ff;
   assign rsp_mem_address = out_maddr_ff;
   assign rsp_mem_value   = out_is_lw_ff ? ld_data : out_mval_ff;
   assign rsp_status      = out_status_ff;

   // ---------------- assertions ----------------
   a_no_write_r0: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (out_dest_ff != '0))
      else $error("register zero written");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_ready)
      else $error("transaction accepted during memory clear");

   a_out_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !ex_fire) |=> !rsp_valid)
      else $error("result repeated after transaction");

   a_status_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (!rsp_reg_write && !rsp_mem_write))
      else $error("unsupported encoding caused a write");

endmodule

`default_nettype wire

// File: dv/tb_risc_subset_instruction_executor.sv
// Self-checking testbench for the MIPS-subset instruction executor.
`timescale 1ns / 1ps

module tb_risc_subset_instruction_executor;
   import rsie_pkg::*;

   localparam int DMEM_WORDS   = 256;
   localparam int RANDOM_ITEMS = 1400;
   localparam int MAX_IDLE     = 10;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 120;
   localparam int MAX_REPORTS  = 100;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      word_type    next_pc;
      logic        reg_write;
      reg_idx_type reg_dest;
      word_type    reg_value;
      logic        mem_write;
      word_type    mem_address;
      word_type    mem_value;
      logic        status;
   } retire_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   word_type    req_instruction = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   word_type    rsp_next_pc;
   logic        rsp_reg_write;
   reg_idx_type rsp_reg_dest;
   word_type    rsp_reg_value;
   logic        rsp_mem_write;
   word_type    rsp_mem_address;
   word_type    rsp_mem_value;
   logic        rsp_status;

   // Pending instruction words and expected retirements
   word_type       instr_stream [$];
   retire_rec_type retire_q [$];

   // Architectural state of the predictor
   word_type arch_gpr [32];
   word_type arch_pc;
   word_type arch_dmem [DMEM_WORDS];

   int unsigned tx_gap = 0;
   int unsigned rx_stall = 0;
   int unsigned rx_hold = 0;
   logic        hold_done = 1'b0;
   int unsigned issued_count = 0;
   int unsigned retired_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned n_loads = 0;
   int unsigned n_stores = 0;
   int unsigned n_taken = 0;
   int unsigned n_jumps = 0;
   int unsigned n_unsupported = 0;

   risc_subset_instruction_executor #(
      .DATA_WORDS(DMEM_WORDS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_instruction(req_instruction),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_reg_write  (rsp_reg_write),
      .rsp_reg_dest   (rsp_reg_dest),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_mem_write  (rsp_mem_write),
      .rsp_mem_address(rsp_mem_address),
      .rsp_mem_value  (rsp_mem_value),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Instruction encoders
   function automatic word_type enc_r(input logic [5:0] funct, input reg_idx_type rs,
                                      input reg_idx_type rt, input reg_idx_type rd,
                                      input logic [4:0] shamt);
      return {OP_RTYPE, rs, rt, rd, shamt, funct};
   endfunction

   function automatic word_type enc_i(input logic [5:0] opcode, input reg_idx_type rs,
                                      input reg_idx_type rt, input logic [15:0] imm);
      return {opcode, rs, rt, imm};
   endfunction

   // Append one instruction word to the pending stream
   function automatic void queue_instr(input word_type w);
      instr_stream.insert(instr_stream.size(), w);
   endfunction

   // Execute one instruction on the architectural state and queue its retirement
   function automatic void execute_and_retire(input word_type instr);
      retire_rec_type r;
      reg_idx_type rs;
      reg_idx_type rt;
      word_type    imm_sx;
      word_type    op_a;
      word_type    op_b;
      word_type    pc_inc;
      word_type    word_idx;
      logic        wr_en;
      r = '0;
      rs = instr[25:21];
      rt = instr[20:16];
      imm_sx = {{16{instr[15]}}, instr[15:0]};
      op_a = arch_gpr[rs];
      op_b = arch_gpr[rt];
      pc_inc = arch_pc + 32'd4;
      r.next_pc = pc_inc;
      wr_en = 1'b0;
      case (instr[31:26])
         OP_RTYPE: begin
            wr_en = 1'b1;
            r.reg_dest = instr[15:11];
            case (instr[5:0])
               FN_ADD: r.reg_value = op_a + op_b;
               FN_SUB: r.reg_value = op_a - op_b;
               FN_AND: r.reg_value = op_a & op_b;
               FN_OR:  r.reg_value = op_a | op_b;
               FN_SLT: r.reg_value = {31'd0, $signed(op_a) < $signed(op_b)};
               default: begin
                  wr_en = 1'b0;
                  r.status = 1'b1;
               end
            endcase
         end
         OP_ADDI: begin
            wr_en = 1'b1;
            r.reg_dest = rt;
            r.reg_value = op_a + imm_sx;
         end
         OP_LW: begin
            r.mem_address = op_a + imm_sx;
            word_idx = r.mem_address >> 2;
            // out-of-range words read as zero
            if (word_idx < DMEM_WORDS) r.mem_value = arch_dmem[word_idx];
            wr_en = 1'b1;
            r.reg_dest = rt;
            r.reg_value = r.mem_value;
            n_loads++;
         end
         OP_SW: begin
            r.mem_address = op_a + imm_sx;
            r.mem_value = op_b;
            r.mem_write = 1'b1;
            word_idx = r.mem_address >> 2;
            // drop stores beyond the memory
            if (word_idx < DMEM_WORDS) arch_dmem[word_idx] = op_b;
            n_stores++;
         end
         OP_BEQ: begin
            if (op_a == op_b) begin
               r.next_pc = pc_inc + (imm_sx << 2);
               n_taken++;
            end
         end
         OP_J: begin
            r.next_pc = {pc_inc[31:28], instr[25:0], 2'b00};
            n_jumps++;
         end
         default: r.status = 1'b1;
      endcase
      if (r.status) n_unsupported++;
      // discard writes to $0
      if (wr_en && r.reg_dest != '0) begin
         r.reg_write = 1'b1;
         arch_gpr[r.reg_dest] = r.reg_value;
      end else begin
         r.reg_dest = '0;
         r.reg_value = '0;
      end
      arch_pc = r.next_pc;
      retire_q.insert(retire_q.size(), r);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS)
         $display("MISMATCH at %0t ns, result %0d: %s", $time, retired_count, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input word_type got, input word_type want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, want %h", field, got, want));
   endtask

   // Driver: present the next instruction after a random gap, predict at accept
   always @(posedge clock) begin : drive_requests
      int unsigned gap_n;
      logic        offer;
      word_type    next_word;
      if (reset) begin
         req_valid <= 1'b0;
         req_instruction <= '0;
         tx_gap <= 0;
      end else begin
         gap_n = tx_gap;
         offer = req_valid;
         next_word = req_instruction;
         if (req_valid && req_ready) begin
            execute_and_retire(req_instruction);
            issued_count <= issued_count + 1;
            offer = 1'b0;
            // back to back while the receiver holds off, and in every third window
            if (rx_hold != 0 || (issued_count / 150) % 3 == 1) gap_n = 0;
            else gap_n = $urandom_range(0, MAX_IDLE);
         end
         if (!offer) begin
            if (gap_n != 0) gap_n = gap_n - 1;
            else if (instr_stream.size() != 0) begin
               next_word = instr_stream.pop_front();
               offer = 1'b1;
            end
         end
         tx_gap <= gap_n;
         req_valid <= offer;
         req_instruction <= next_word;
      end
   end

   // Monitor: check each retirement against the oldest prediction, stall at random
   always @(posedge clock) begin : watch_results
      int unsigned    stall_n;
      retire_rec_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall <= 0;
      end else begin
         stall_n = rx_stall;
         if (rsp_valid && rsp_ready) begin
            retired_count <= retired_count + 1;
            if (retire_q.size() == 0) begin
               report_mismatch("result with no instruction outstanding");
            end else begin
               want = retire_q.pop_front();
               check_field("next_pc", rsp_next_pc, want.next_pc);
               check_field("reg_write", word_type'(rsp_reg_write),
                           word_type'(want.reg_write));
               check_field("reg_dest", word_type'(rsp_reg_dest),
                           word_type'(want.reg_dest));
               check_field("reg_value", rsp_reg_value, want.reg_value);
               check_field("mem_write", word_type'(rsp_mem_write),
                           word_type'(want.mem_write));
               check_field("mem_address", rsp_mem_address, want.mem_address);
               check_field("mem_value", rsp_mem_value, want.mem_value);
               check_field("status", word_type'(rsp_status), word_type'(want.status));
            end
            if ((retired_count / 170) % 3 == 2) stall_n = 0;
            else stall_n = $urandom_range(0, MAX_IDLE);
         end else if (stall_n != 0) begin
            stall_n = stall_n - 1;
         end
         rx_stall <= stall_n;
         rsp_ready <= (stall_n == 0) && (rx_hold == 0);
      end
   end

   // Hold off the result side once for a long stretch so the block backs up
   always @(posedge clock) begin : backlog_hold
      if (reset) begin
         rx_hold <= 0;
         hold_done <= 1'b0;
      end else if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else if (!hold_done && retired_count >= HOLD_AT) begin
         rx_hold <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [5:0]  rtype_functs [5];
      int unsigned pick;
      int unsigned cls;
      reg_idx_type ra;
      reg_idx_type rb;
      reg_idx_type rc;
      logic [15:0] imm;
      word_type    w;
      rtype_functs = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};
      arch_pc = '0;
      foreach (arch_gpr[i]) arch_gpr[i] = '0;
      foreach (arch_dmem[i]) arch_dmem[i] = '0;

      // Directed: immediate extremes to seed registers
      queue_instr(enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7FFF));
      queue_instr(enc_i(OP_ADDI, 5'd0, 5'd2, 16'hFFFF));
      queue_instr(enc_i(OP_ADDI, 5'd0, 5'd3, 16'h8000));
      // every R-type operation, wrapping add, nonzero shamt, signed slt both ways
      queue_instr(enc_r(FN_ADD, 5'd2, 5'd1, 5'd31, 5'd0));
      queue_instr(enc_r(FN_SUB, 5'd3, 5'd1, 5'd5, 5'd31));
      queue_instr(enc_r(FN_AND, 5'd2, 5'd3, 5'd6, 5'd0));
      queue_instr(enc_r(FN_OR, 5'd1, 5'd3, 5'd7, 5'd0));
      queue_instr(enc_r(FN_SLT, 5'd3, 5'd1, 5'd8, 5'd0));
      queue_instr(enc_r(FN_SLT, 5'd1, 5'd3, 5'd9, 5'd0));
      // write to $0 is dropped
      queue_instr(enc_r(FN_ADD, 5'd2, 5'd2, 5'd0, 5'd0));
      // stores at first and last word, unaligned addresses, beyond memory
      queue_instr(enc_i(OP_SW, 5'd0, 5'd2, 16'd0));
      queue_instr(enc_i(OP_SW, 5'd0, 5'd1, 16'd1023));
      queue_instr(enc_i(OP_LW, 5'd0, 5'd10, 16'd1020));
      queue_instr(enc_i(OP_LW, 5'd0, 5'd11, 16'd3));
      queue_instr(enc_i(OP_SW, 5'd0, 5'd1, 16'd1024));
      queue_instr(enc_i(OP_LW, 5'd0, 5'd12, 16'd1024));
      queue_instr(enc_i(OP_LW, 5'd0, 5'd13, 16'hFFFC));
      // load into $0 still reports the access
      queue_instr(enc_i(OP_LW, 5'd0, 5'd0, 16'd0));
      // branches taken backward, not taken, taken far forward; jumps at extremes
      queue_instr(enc_i(OP_BEQ, 5'd1, 5'd1, 16'hFFFF));
      queue_instr(enc_i(OP_BEQ, 5'd1, 5'd2, 16'd5));
      queue_instr(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h7FFF));
      queue_instr({OP_J, 26'h3FFFFFF});
      queue_instr({OP_J, 26'h0});
      // unknown funct and unknown opcode
      queue_instr(32'h0000_0000);
      queue_instr(32'hFFFF_FFFF);

      // Random: mostly well-formed instructions, some unsupported encodings and noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         cls = $urandom_range(0, 99);
         ra = reg_idx_type'($urandom_range(0, 31));
         rb = reg_idx_type'($urandom_range(0, 31));
         rc = reg_idx_type'($urandom_range(0, 31));
         imm = 16'($urandom);
         w = $urandom;
         if (cls < 7) begin
            queue_instr(w);
         end else if (cls < 13) begin
            // funct bit 4 or opcode bit 4 set never decodes to a supported operation
            if (cls < 10) begin
               w[31:26] = OP_RTYPE;
               w[4] = 1'b1;
            end else begin
               w[30] = 1'b1;
            end
            queue_instr(w);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               queue_instr(enc_r(rtype_functs[3'($urandom_range(0, 4))], ra, rb, rc,
                                 w[10:6]));
            end else if (pick < 55) begin
               queue_instr(enc_i(OP_ADDI, ra, rb, imm));
            end else if (pick < 85) begin
               // keep half the accesses on a small window so loads see earlier stores
               cls = $urandom_range(0, 9);
               if (cls < 5) begin
                  ra = '0;
                  imm = 16'($urandom_range(0, 127));
               end else if (cls < 7) begin
                  ra = '0;
                  imm = 16'($urandom_range(0, 1023));
               end else if (cls < 8) begin
                  ra = '0;
                  imm = 16'($urandom_range(1024, 65535));
               end
               queue_instr(enc_i((pick < 70) ? OP_LW : OP_SW, ra, rb, imm));
            end else if (pick < 95) begin
               if ($urandom_range(0, 9) < 3) rb = ra;
               queue_instr(enc_i(OP_BEQ, ra, rb, imm));
            end else begin
               queue_instr({OP_J, w[25:0]});
            end
         end
      end

      // Release reset
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Drain: wait for every instruction to retire, then let the bench idle before the final check
      @(negedge clock);
      while (instr_stream.size() != 0 || req_valid || retire_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (retire_q.size() != 0)
         report_mismatch($sformatf("%0d predictions never retired", retire_q.size()));

      $display("Executed %0d instructions, %0d results checked: %0d loads, %0d stores,",
               issued_count, retired_count, n_loads, n_stores);
      $display("%0d taken branches, %0d jumps, %0d unsupported, one %0d-cycle output stall",
               n_taken, n_jumps, n_unsupported, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
